// File: hw/rtl/sips_pkg.sv
// ----------------------------------------------------------------------------
// sips_pkg
// Shared types and constants of the ultrasonic ranger poll sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sips_pkg;

	// stream payload widths, padded to whole bytes, and cfg channel widths
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 40;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 8;

	// register reset values
	localparam logic [7:0] DevAddrRst  = 8'hE0;
	localparam logic [6:0] RangeCmdRst = 7'h51;
	localparam logic [3:0] RangeSetRst = 4'd3;
	localparam logic [4:0] GainRst     = 5'd0;

	// range register byte is the low byte of range_setting times this factor
	localparam logic [7:0] RangeScale  = 8'd23;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEV_ADDR  = 2'd0,
		CFG_RANGE_CMD = 2'd1,
		CFG_RANGE_SET = 2'd2,
		CFG_GAIN      = 2'd3
	} cfg_idx_t;

	// input item kinds
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_DONE = 1'b1
	} op_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_READ  = 3'd2,
		KIND_RANGE = 3'd3,
		KIND_LIGHT = 3'd4
	} kind_t;

	// device registers
	localparam logic [1:0] DevRegCmd   = 2'd0;
	localparam logic [1:0] DevRegGain  = 2'd1;
	localparam logic [1:0] DevRegRange = 2'd2;

	// read lengths
	localparam logic [1:0] ReadOne = 2'd1;
	localparam logic [1:0] ReadTwo = 2'd2;

	// polling steps, one-hot
	typedef enum logic [6:0] {
		STEP_START        = 7'b0000001,
		STEP_SET_RANGE    = 7'b0000010,
		STEP_SET_GAIN     = 7'b0000100,
		STEP_REQ_RANGE    = 7'b0001000,
		STEP_REPORT_RANGE = 7'b0010000,
		STEP_REQ_LIGHT    = 7'b0100000,
		STEP_REPORT_LIGHT = 7'b1000000
	} step_t;

	// configuration register set
	typedef struct packed {
		logic [7:0] device_address;
		logic [6:0] ranging_command;
		logic [3:0] range_setting;
		logic [4:0] max_gain;
	} cfg_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  bus_address;
		logic [1:0]  register_index;
		logic [7:0]  write_byte;
		logic [1:0]  read_count;
		logic [15:0] report_value;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sips_cfg_regs.sv
// ----------------------------------------------------------------------------
// sips_cfg_regs
// Configuration register file, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_cfg_regs
	import sips_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= DevAddrRst;
			cfg_q.ranging_command <= RangeCmdRst;
			cfg_q.range_setting   <= RangeSetRst;
			cfg_q.max_gain        <= GainRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEV_ADDR:  cfg_q.device_address  <= cfg_data;
				CFG_RANGE_CMD: cfg_q.ranging_command <= cfg_data[6:0];
				CFG_RANGE_SET: cfg_q.range_setting   <= cfg_data[3:0];
				CFG_GAIN:      cfg_q.max_gain        <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sips_step_core.sv
// ----------------------------------------------------------------------------
// sips_step_core
// Step state, outstanding flag and read data, plus the result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_step_core
	import sips_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic       op,
	input  wire logic       trans_ok,
	input  wire logic [7:0] read_first,
	input  wire logic [7:0] read_second,
	input  wire cfg_t       cfg,
	output result_t         result
);

	step_t       step_q, step_d;
	logic        busy_q, busy_d;
	logic [15:0] read_bytes_q, read_bytes_d;
	logic [11:0] range_prod;

	assign range_prod = {8'd0, cfg.range_setting} * {4'd0, RangeScale};

	// result and next state for the item in the input register
	always_comb begin
		result       = '0;
		result.kind  = KIND_NONE;
		step_d       = step_q;
		busy_d       = busy_q;
		read_bytes_d = read_bytes_q;
		if (op_t'(op) == OP_TICK) begin
			if (!busy_q) begin
				unique case (step_q)
					STEP_START: begin
						result.kind           = KIND_WRITE;
						result.register_index = DevRegCmd;
						result.write_byte     = {1'b0, cfg.ranging_command};
						busy_d                = 1'b1;
					end
					STEP_SET_RANGE: begin
						result.kind           = KIND_WRITE;
						result.register_index = DevRegRange;
						result.write_byte     = range_prod[7:0];
						busy_d                = 1'b1;
					end
					STEP_SET_GAIN: begin
						result.kind           = KIND_WRITE;
						result.register_index = DevRegGain;
						result.write_byte     = {3'd0, cfg.max_gain};
						busy_d                = 1'b1;
					end
					STEP_REQ_RANGE: begin
						result.kind           = KIND_READ;
						result.register_index = DevRegRange;
						result.read_count     = ReadTwo;
						busy_d                = 1'b1;
					end
					STEP_REPORT_RANGE: begin
						result.kind         = KIND_RANGE;
						result.report_value = read_bytes_q;
						step_d              = STEP_REQ_LIGHT;
					end
					STEP_REQ_LIGHT: begin
						result.kind           = KIND_READ;
						result.register_index = DevRegGain;
						result.read_count     = ReadOne;
						busy_d                = 1'b1;
					end
					STEP_REPORT_LIGHT: begin
						result.kind         = KIND_LIGHT;
						result.report_value = {8'd0, read_bytes_q[15:8]};
						step_d              = STEP_START;
					end
					default: begin
					end
				endcase
				// address only on bus requests
				if (result.kind == KIND_WRITE || result.kind == KIND_READ) begin
					result.bus_address = cfg.device_address;
				end
			end
		end else if (busy_q) begin
			// completion ends the outstanding transaction
			busy_d = 1'b0;
			if (trans_ok) begin
				read_bytes_d = {read_first, read_second};
				unique case (step_q)
					STEP_START:     step_d = STEP_SET_RANGE;
					STEP_SET_RANGE: step_d = STEP_SET_GAIN;
					STEP_SET_GAIN:  step_d = STEP_REQ_RANGE;
					STEP_REQ_RANGE: step_d = STEP_REPORT_RANGE;
					STEP_REQ_LIGHT: step_d = STEP_REPORT_LIGHT;
					default: begin
					end
				endcase
			end
		end
	end

	// state update once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_START;
			busy_q       <= 1'b0;
			read_bytes_q <= '0;
		end else if (fire) begin
			step_q       <= step_d;
			busy_q       <= busy_d;
			read_bytes_q <= read_bytes_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sonar_i2c_poll_sequencer.sv
// ----------------------------------------------------------------------------
// sonar_i2c_poll_sequencer
// Poll sequencer for an I2C ultrasonic ranger with stream in and out ports.
// ----------------------------------------------------------------------------
// Every input beat (a poll tick or a bus completion) gives exactly one output
// beat, possibly of kind nothing. One beat is taken per clock while the output
// side keeps up; a beat enters an input register, is decoded against the step
// state combinationally and lands in the result register once that register
// is free or draining. The input register and the result register form a
// two-deep queue, so a waiting result does not stop the next beat coming in.
// Configuration is to be written over the cfg channel while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module sonar_i2c_poll_sequencer
	import sips_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// trans_ok [0], read_first [8:1], read_second [16:9], zero pad
	input  wire logic [InDataW-1:0]  s_tdata,
	// op [0]
	input  wire logic                s_tuser,
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// bus_address [7:0], register_index [9:8], write_byte [17:10],
	// read_count [19:18], report_value [35:20], zero pad
	output logic [OutDataW-1:0]      m_tdata,
	// kind [2:0]
	output logic [2:0]               m_tuser,
	// configuration writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t        cfg;
	result_t     result;
	logic        valid_s1;
	logic        op_s1;
	logic        ok_s1;
	logic [7:0]  first_s1;
	logic [7:0]  second_s1;
	logic        advance;
	logic        m_tvalid_q;
	result_t     result_q;

	sips_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register moves on when the result register is free or draining
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tuser;
			ok_s1     <= s_tdata[0];
			first_s1  <= s_tdata[8:1];
			second_s1 <= s_tdata[16:9];
		end
	end

	sips_step_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.op          (op_s1),
		.trans_ok    (ok_s1),
		.read_first  (first_s1),
		.read_second (second_s1),
		.cfg         (cfg),
		.result      (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	// output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = result_q.kind;
	assign m_tdata  = {4'd0, result_q.report_value, result_q.read_count,
		result_q.write_byte, result_q.register_index, result_q.bus_address};

endmodule

`default_nettype wire
